/* sv/angle_average_lever_report_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the angle average lever report unit
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ANGLE_AVERAGE_LEVER_REPORT_UNIT_ASSERT_SVH
`define ANGLE_AVERAGE_LEVER_REPORT_UNIT_ASSERT_SVH

// Same-cycle implication
`define AALR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define AALR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/aalr_pkg.sv */
// ----------------------------------------------------------------------------
// aalr_pkg
// Widths and fixed constants shared by the lever report unit and its parts.
// ----------------------------------------------------------------------------
package aalr_pkg;

   localparam int BTN_W       = 11;
   localparam int ANGLE_W     = 16;
   localparam int LEFT_W      = 5;
   localparam int RIGHT_W     = 6;
   localparam int RAW_W       = 10;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;

   // Mean angle in 1/16 degree, clamped to 0..360 degrees
   localparam int              MEAN_W   = 13;
   localparam logic [MEAN_W-1:0] MEAN_MAX = 13'd5760;

endpackage

/* sv/aalr_ring.sv */
// ----------------------------------------------------------------------------
// aalr_ring
// Sample ring memory with running window sum, write slot and fill count.
// ----------------------------------------------------------------------------
module aalr_ring import aalr_pkg::*; #(
   parameter int WINDOW = 8,
   parameter int SUM_W  = 20,
   parameter int CNT_W  = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  logic [ANGLE_W-1:0]      sample,
   output logic                    done,
   output logic signed [SUM_W-1:0] sum,
   output logic [CNT_W-1:0]        fill
);

   `include "angle_average_lever_report_unit_assert.svh"

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0]  FILL_FULL = CNT_W'(WINDOW);

   logic [ANGLE_W-1:0]      ring_mem [WINDOW];
   logic [ANGLE_W-1:0]      rd_data_ff;
   logic [ANGLE_W-1:0]      sample_ff;
   logic                    pend_ff, pend_in;
   logic                    done_ff, done_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [ANGLE_W-1:0]      old_val;
   logic signed [SUM_W-1:0] old_ext, new_ext;

   // Read the slot on accept, write the new sample back in the cycle after
   always_ff @(posedge clock) begin
      if (go) begin
         rd_data_ff <= ring_mem[slot_ff];
         sample_ff  <= sample;
      end
      if (pend_ff) begin
         ring_mem[slot_ff] <= sample_ff;
      end
   end

   // Slots not yet written count as zero until the ring has filled once
   always_comb begin
      old_val = (fill_ff == FILL_FULL) ? rd_data_ff : '0;
      old_ext = SUM_W'(signed'(old_val));
      new_ext = SUM_W'(signed'(sample_ff));
      pend_in = go;
      done_in = pend_ff;
      sum_in  = sum_ff;
      slot_in = slot_ff;
      fill_in = fill_ff;
      if (pend_ff) begin
         sum_in  = sum_ff - old_ext + new_ext;
         slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
         if (fill_ff != FILL_FULL) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
         sum_ff  <= '0;
         slot_ff <= '0;
         fill_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         done_ff <= done_in;
         sum_ff  <= sum_in;
         slot_ff <= slot_in;
         fill_ff <= fill_in;
      end
   end

   assign done = done_ff;
   assign sum  = sum_ff;
   assign fill = fill_ff;

   `AALR_ASSERT_IMP(a_ring_fill_max, 1'b1, fill_ff <= FILL_FULL, "fill count above window")
   `AALR_ASSERT_IMP(a_ring_no_overlap, go, !pend_ff, "ring access overlaps write-back")
   `AALR_ASSERT_IMP(a_ring_done_fill, done_ff, fill_ff != '0, "ring done with empty window")

endmodule

/* sv/aalr_div.sv */
// ----------------------------------------------------------------------------
// aalr_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aalr_div import aalr_pkg::*; #(
   parameter int DVD_W = 19,
   parameter int DVS_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   `include "angle_average_lever_report_unit_assert.svh"

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  den_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial, diff;
   logic              fits;

   // Shift in the next dividend bit and subtract where it fits
   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = STEP_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         rem_in  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `AALR_ASSERT_IMP(a_div_start_idle, start, !busy_ff, "divider started while busy")
   `AALR_ASSERT_IMP(a_div_nonzero, start, divisor != '0, "divide by zero")
   `AALR_ASSERT_IMP(a_div_step_live, busy_ff, step_ff != '0, "divider busy with no steps left")

endmodule

/* sv/aalr_lever.sv */
// ----------------------------------------------------------------------------
// aalr_lever
// Map the clamped mean angle to the 10-bit raw lever code in four steps.
// ----------------------------------------------------------------------------
module aalr_lever import aalr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [MEAN_W-1:0] mean,
   output logic              done,
   output logic [RAW_W-1:0]  lever_raw
);

   localparam int MAG_W = 21;
   localparam int Q_W   = 16;
   localparam int SH_W  = 16;
   localparam logic [MAG_W:0]   LEVER_OFS = 22'd1474560;
   localparam logic [18:0]      RECIP45   = 19'd372827;
   localparam int               SHIFT45   = 24;
   localparam logic [MAG_W:0]   DIV45     = 22'd45;
   localparam logic [13:0]      RECIP80   = 14'd13107;
   localparam int               SHIFT80   = 20;
   localparam logic [SH_W-1:0]  DIV80     = 16'd80;
   localparam logic [Q_W-1:0]   LEVER_MAX = 16'd32767;

   logic [3:0]        vld_ff, vld_in;
   logic [MAG_W-1:0]  mag_ff;
   logic              neg_ff;
   logic [39:0]       prod1_ff;
   logic [SH_W-1:0]   sh_ff, sh2_ff;
   logic [29:0]       prod2_ff;
   logic [RAW_W-1:0]  raw_ff;
   logic [MAG_W:0]    scaled, mag_w;
   logic [Q_W-1:0]    q45, q45_fix;
   logic [MAG_W:0]    r45;
   logic [SH_W-1:0]   sh_in;
   logic [RAW_W-1:0]  q80;
   logic [SH_W-1:0]   r80;

   function automatic logic [MAG_W:0] mag_w_ext(input logic [MAG_W-1:0] m);
      mag_w_ext = {1'b0, m};
   endfunction

   // Magnitude of 512*m - 1474560 and its sign
   always_comb begin
      scaled = {mean, 9'd0};
      mag_w  = (scaled < LEVER_OFS) ? LEVER_OFS - scaled : scaled - LEVER_OFS;
   end

   // Divide by 45 through a reciprocal, then correct by one
   always_comb begin
      q45     = prod1_ff[SHIFT45 +: Q_W];
      r45     = mag_w_ext(mag_ff) - {6'd0, q45} * DIV45;
      q45_fix = (r45 >= DIV45) ? q45 + 1'b1 : q45;
      if (neg_ff) begin
         sh_in = (q45_fix > LEVER_MAX) ? '0 : LEVER_MAX - q45_fix;
      end else begin
         sh_in = LEVER_MAX + ((q45_fix > LEVER_MAX) ? LEVER_MAX : q45_fix);
      end
   end

   // Divide by 80 through a reciprocal, then correct by one
   always_comb begin
      q80 = prod2_ff[SHIFT80 +: RAW_W];
      r80 = sh2_ff - SH_W'({6'd0, q80} * DIV80);
   end

   always_ff @(posedge clock) begin
      if (vld_in[0]) begin
         mag_ff   <= mag_w[MAG_W-1:0];
         neg_ff   <= (scaled < LEVER_OFS);
         prod1_ff <= 40'(mag_w[MAG_W-1:0] * RECIP45);
      end
      if (vld_ff[0]) begin
         sh_ff <= sh_in;
      end
      if (vld_ff[1]) begin
         prod2_ff <= 30'(sh_ff * RECIP80);
         sh2_ff   <= sh_ff;
      end
      if (vld_ff[2]) begin
         raw_ff <= (r80 >= DIV80) ? q80 + 1'b1 : q80;
      end
   end

   // Advance the step valid chain
   assign vld_in = {vld_ff[2:0], go};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign done      = vld_ff[3];
   assign lever_raw = raw_ff;

endmodule

/* sv/angle_average_lever_report_unit.sv */
// ----------------------------------------------------------------------------
// angle_average_lever_report_unit
// Button packing plus a moving-average angle mapped to a raw lever code.
// ----------------------------------------------------------------------------
//  Channel | Direction | Beat contents
//  req_    | in        | tdata[10:0] button_levels, tdata[26:11] angle_sample
//  rsp_    | out       | tdata[4:0] left_byte, [10:5] right_byte, [20:11] lever_raw
//
//  One item at a time: accept, ring read, ring update, SUM_W-1 divider steps,
//  four mapping steps, then the result register.
//  The bit-serial mean divider is the longest part of that sequence.
//  A new beat is taken as soon as the previous result sits in the output register.
//  A stalled result holds the block before its output load; reset empties the ring
//  at once through the fill count, with no clearing pass.
// ----------------------------------------------------------------------------
module angle_average_lever_report_unit import aalr_pkg::*; #(
   parameter int WINDOW = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // button_levels[10:0], angle_sample[26:11]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // left_byte[4:0], right_byte[10:5], lever_raw[20:11]
);

   `include "angle_average_lever_report_unit_assert.svh"

   localparam int SUM_W = 17 + $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int Q_W   = SUM_W - 1;
   localparam int PAD_W = RSP_TDATA_W - LEFT_W - RIGHT_W - RAW_W;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RING = 5'b00010,
      S_DIV  = 5'b00100,
      S_MAP  = 5'b01000,
      S_WAIT = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic                    req_beat;
   logic [BTN_W-1:0]        btn_ff;
   logic                    ring_done;
   logic signed [SUM_W-1:0] ring_sum;
   logic [CNT_W-1:0]        ring_fill;
   logic [Q_W-1:0]          div_dividend, div_quo;
   logic                    div_done;
   logic [MEAN_W-1:0]       mean;
   logic                    lev_done;
   logic [RAW_W-1:0]        lev_raw;
   logic                    out_free, out_load;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;

   aalr_ring #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W),
      .CNT_W  (CNT_W)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .go     (req_beat),
      .sample (req_tdata[BTN_W +: ANGLE_W]),
      .done   (ring_done),
      .sum    (ring_sum),
      .fill   (ring_fill)
   );

   // A negative sum gives a mean of zero after the clamp
   assign div_dividend = ring_sum[SUM_W-1] ? '0 : ring_sum[Q_W-1:0];

   aalr_div #(
      .DVD_W (Q_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ring_done),
      .dividend (div_dividend),
      .divisor  (ring_fill),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Clamp the mean to 360 degrees
   assign mean = (div_quo > Q_W'(MEAN_MAX)) ? MEAN_MAX : div_quo[MEAN_W-1:0];

   aalr_lever u_lever (
      .clock     (clock),
      .reset     (reset),
      .go        (div_done),
      .mean      (mean),
      .done      (lev_done),
      .lever_raw (lev_raw)
   );

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign out_load = ((state_ff == S_MAP && lev_done) || state_ff == S_WAIT) && out_free;

   // Sequence one item through ring, divider and mapping
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) state_in = S_RING;
         end
         S_RING: begin
            if (ring_done) state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) state_in = S_MAP;
         end
         S_MAP: begin
            if (lev_done) state_in = out_free ? S_IDLE : S_WAIT;
         end
         S_WAIT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the result until the beat is taken
   assign rsp_tvalid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         btn_ff <= req_tdata[BTN_W-1:0];
      end
      if (out_load) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, lev_raw, btn_ff[10], btn_ff[9:5], btn_ff[4:0]};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `AALR_ASSERT_IMP(a_top_ring_state, ring_done, state_ff == S_RING, "ring done out of sequence")
   `AALR_ASSERT_IMP(a_top_div_state, div_done, state_ff == S_DIV, "divider done out of sequence")
   `AALR_ASSERT_IMP(a_top_no_overwrite, out_load, !rsp_tvalid_ff || rsp_tready,
      "result register overwritten")

endmodule
